@@ src/spifp_pkg.sv @@
// Shared types, opcodes and helpers for the SPI flash image programmer.
// No dependencies; imported by every module of the block.
package spifp_pkg;

  // Flash opcodes
  localparam logic [7:0] OP_EWSR   = 8'h50;
  localparam logic [7:0] OP_WRSR   = 8'h01;
  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_CE     = 8'hC7;
  localparam logic [7:0] OP_PP     = 8'h02;
  localparam logic [7:0] OP_RDSR   = 8'h05;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  // Status register busy bit
  localparam int unsigned STATUS_BUSY_BIT = 0;

  // Depth of the front-to-back job queue
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_STATUS = 2'd2
  } cmd_e;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_ERASE_POLL = 5'b00010,
    PH_ACCEPT     = 5'b00100,
    PH_PAGE_POLL  = 5'b01000,
    PH_DONE       = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    JOB_BEGIN = 3'd0,
    JOB_DATA  = 3'd1,
    JOB_POLL  = 3'd2,
    JOB_WREN  = 3'd3,
    JOB_DONE  = 3'd4
  } job_kind_e;

  // One queued job: what the back end has to put on the wire
  typedef struct packed {
    job_kind_e  kind;
    logic       hdr;    // page program header goes first
    logic       last;   // page ends with this byte, poll follows
    logic [7:0] data;   // image byte, already bit-reversed
  } job_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       end_select;
    logic       capture_reply;
    logic       hold_reset;
    logic       update_done;
  } res_t;

  function automatic logic [7:0] bit_reverse(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // Begin sequence: unprotect, write status, write enable, erase, poll
  function automatic res_t begin_step(input logic [2:0] idx);
    res_t r;
    r = '{spi_byte: BYTE_ZERO, end_select: 1'b1, capture_reply: 1'b0,
          hold_reset: 1'b1, update_done: 1'b0};
    unique case (idx)
      3'd0: r.spi_byte = OP_EWSR;
      3'd1: begin
        r.spi_byte   = OP_WRSR;
        r.end_select = 1'b0;
      end
      3'd2: r.spi_byte = BYTE_ZERO;
      3'd3: r.spi_byte = OP_WREN;
      3'd4: r.spi_byte = OP_CE;
      3'd5: begin
        r.spi_byte   = OP_RDSR;
        r.end_select = 1'b0;
      end
      3'd6: r.capture_reply = 1'b1;
      default: r.spi_byte = BYTE_ZERO;
    endcase
    return r;
  endfunction

endpackage

@@ src/spifp_front.sv @@
// Front end: accepts input transactions, tracks programming phase and page
// position, and turns each accepted transaction into at most one queued job. Uses spifp_pkg.
module spifp_front import spifp_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = 256,
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              cmd_i,
  input  logic [7:0]              data_i,
  input  logic                    final_byte_i,
  input  logic                    full_i,
  output logic                    push_o,
  output job_t                    job_o,
  output logic [ADDRESS_BITS-1:0] addr_o
);

  localparam int unsigned OFF_W = $clog2(PAGE_BYTES + 1);

  phase_e                  phase_q, phase_d;
  logic [ADDRESS_BITS-1:0] addr_q, addr_d;
  logic [OFF_W-1:0]        offset_q, offset_d, offset_inc;
  logic                    fin_q, fin_d;
  logic                    accept, last;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign offset_inc = offset_q + OFF_W'(1);
  assign last       = final_byte_i || (offset_inc == OFF_W'(PAGE_BYTES));
  assign addr_o     = addr_q;

  always_comb begin
    phase_d  = phase_q;
    addr_d   = addr_q;
    offset_d = offset_q;
    fin_d    = fin_q;
    push_o   = 1'b0;
    job_o    = '{kind: JOB_WREN, hdr: 1'b0, last: 1'b0, data: BYTE_ZERO};
    if (accept) begin
      unique case (cmd_e'(cmd_i))
        CMD_BEGIN: begin
          if (phase_q == PH_IDLE || phase_q == PH_DONE) begin
            addr_d     = '0;
            offset_d   = '0;
            fin_d      = 1'b0;
            push_o     = 1'b1;
            job_o.kind = JOB_BEGIN;
            phase_d    = PH_ERASE_POLL;
          end
        end
        CMD_DATA: begin
          if (phase_q == PH_ACCEPT) begin
            push_o     = 1'b1;
            job_o.kind = JOB_DATA;
            job_o.hdr  = (offset_q == '0);
            job_o.last = last;
            job_o.data = bit_reverse(data_i);
            if (last) begin
              addr_d   = addr_q + ADDRESS_BITS'(PAGE_BYTES);
              offset_d = '0;
              fin_d    = final_byte_i;
              phase_d  = PH_PAGE_POLL;
            end else begin
              offset_d = offset_inc;
            end
          end
        end
        CMD_STATUS: begin
          if (phase_q == PH_ERASE_POLL || phase_q == PH_PAGE_POLL) begin
            push_o = 1'b1;
            if (data_i[STATUS_BUSY_BIT]) begin
              job_o.kind = JOB_POLL;
            end else if (phase_q == PH_PAGE_POLL && fin_q) begin
              job_o.kind = JOB_DONE;
              phase_d    = PH_DONE;
            end else begin
              job_o.kind = JOB_WREN;
              phase_d    = PH_ACCEPT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      addr_q   <= '0;
      offset_q <= '0;
      fin_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      addr_q   <= addr_d;
      offset_q <= offset_d;
      fin_q    <= fin_d;
    end
  end

endmodule

@@ src/spifp_queue.sv @@
// Short job queue between front and back ends, with page address alongside.
// Uses spifp_pkg for the job type and depth.
module spifp_queue import spifp_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  job_t                    job_i,
  input  logic [ADDRESS_BITS-1:0] addr_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    head_valid_o,
  output job_t                    head_job_o,
  output logic [ADDRESS_BITS-1:0] head_addr_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t                    job_mem_q  [QUEUE_DEPTH];
  logic [ADDRESS_BITS-1:0] addr_mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]        count_q, count_d;

  assign full_o       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = job_mem_q[rd_ptr_q];
  assign head_addr_o  = addr_mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      job_mem_q[wr_ptr_q]  <= job_i;
      addr_mem_q[wr_ptr_q] <= addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
    end
  end

  overflow_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |-> pop_i)
    else $error("job queue overflow");

  underflow_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("job queue underflow");

endmodule

@@ src/spifp_back.sv @@
// Back end: steps through the head job one SPI byte per cycle while the output is
// not stalled, and drives the registered output transaction. Uses spifp_pkg.
module spifp_back import spifp_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    head_valid_i,
  input  job_t                    head_job_i,
  input  logic [ADDRESS_BITS-1:0] head_addr_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              spi_byte_o,
  output logic                    end_select_o,
  output logic                    capture_reply_o,
  output logic                    hold_reset_o,
  output logic                    update_done_o,
  output logic                    run_end_o
);

  localparam int unsigned ADDR_BYTES = (ADDRESS_BITS + 7) / 8;
  localparam int unsigned PAD_W      = ADDR_BYTES * 8;
  localparam int unsigned MAX_STEPS  = (ADDR_BYTES + 4 > 7) ? ADDR_BYTES + 4 : 7;
  localparam int unsigned STEP_W     = $clog2(MAX_STEPS + 1);

  logic [STEP_W-1:0] step_q, step_d, n_steps, hdr_len, byte_idx;
  logic [PAD_W-1:0]  addr_pad;
  logic              out_ready, emit, last_step;
  res_t              res, res_q;
  logic              out_valid_q, run_end_q;

  assign addr_pad  = PAD_W'(head_addr_i);
  assign hdr_len   = head_job_i.hdr ? STEP_W'(ADDR_BYTES + 1) : '0;
  assign byte_idx  = STEP_W'(ADDR_BYTES) - step_q;
  assign out_ready = !out_valid_q || !out_stall_i;
  assign emit      = head_valid_i && out_ready;
  assign last_step = (step_q == n_steps - STEP_W'(1));
  assign pop_o     = emit && last_step;
  assign step_d    = pop_o ? '0 : (emit ? step_q + STEP_W'(1) : step_q);

  always_comb begin
    res = '{spi_byte: BYTE_ZERO, end_select: 1'b0, capture_reply: 1'b0,
            hold_reset: 1'b1, update_done: 1'b0};
    n_steps = STEP_W'(1);
    unique case (head_job_i.kind)
      JOB_BEGIN: begin
        n_steps = STEP_W'(7);
        res     = begin_step(step_q[2:0]);
      end
      JOB_DATA: begin
        n_steps = hdr_len + (head_job_i.last ? STEP_W'(3) : STEP_W'(1));
        if (head_job_i.hdr && step_q == '0) begin
          res.spi_byte = OP_PP;
        end else if (step_q < hdr_len) begin
          // address bytes, most significant first
          res.spi_byte = 8'(addr_pad >> {byte_idx, 3'b000});
        end else if (step_q == hdr_len) begin
          res.spi_byte   = head_job_i.data;
          res.end_select = head_job_i.last;
        end else if (step_q == hdr_len + STEP_W'(1)) begin
          res.spi_byte = OP_RDSR;
        end else begin
          res.end_select    = 1'b1;
          res.capture_reply = 1'b1;
        end
      end
      JOB_POLL: begin
        n_steps = STEP_W'(2);
        if (step_q == '0) begin
          res.spi_byte = OP_RDSR;
        end else begin
          res.end_select    = 1'b1;
          res.capture_reply = 1'b1;
        end
      end
      JOB_WREN: begin
        res.spi_byte   = OP_WREN;
        res.end_select = 1'b1;
      end
      JOB_DONE: begin
        res.hold_reset  = 1'b0;
        res.update_done = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (out_ready) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q     <= res;
      run_end_q <= last_step;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign spi_byte_o      = res_q.spi_byte;
  assign end_select_o    = res_q.end_select;
  assign capture_reply_o = res_q.capture_reply;
  assign hold_reset_o    = res_q.hold_reset;
  assign update_done_o   = res_q.update_done;
  assign run_end_o       = run_end_q;

  step_bound_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> step_q < n_steps)
    else $error("step counter past end of job");

  step_clear_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> step_q == '0)
    else $error("step counter not cleared after job");

  done_alone_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.update_done |-> run_end_q && !res_q.hold_reset)
    else $error("done report not a lone transaction");

endmodule

@@ src/spi_flash_image_programmer.sv @@
// An accepted transaction is written into the job queue; its result then goes valid
//   when it is loaded into the output register.
// Throughput: while the output is not stalled, the back end sends one result per cycle;
//   one-result transactions are taken every cycle, page header (address, poll) and begin
//   items hold it longer. Input stalls only while the 4-entry job queue is full.
// Reset: async active low, clears phase, address, page position, queue and output valid.
module spi_flash_image_programmer import spifp_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = 256,
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] data_i,
  input  logic       final_byte_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] spi_byte_o,
  output logic       end_select_o,
  output logic       capture_reply_o,
  output logic       hold_reset_o,
  output logic       update_done_o,
  output logic       run_end_o
);

  // Front -> queue
  logic                    push, full;
  job_t                    push_job;
  logic [ADDRESS_BITS-1:0] push_addr;

  // Queue -> back
  logic                    pop, head_valid;
  job_t                    head_job;
  logic [ADDRESS_BITS-1:0] head_addr;

  // Front end decides everything about phase and page position at accept
  // time, so each transaction maps to at most one job.
  spifp_front #(
    .PAGE_BYTES  (PAGE_BYTES),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .data_i      (data_i),
    .final_byte_i(final_byte_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job),
    .addr_o      (push_addr)
  );

  spifp_queue #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (push_job),
    .addr_i      (push_addr),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_job_o  (head_job),
    .head_addr_o (head_addr)
  );

  // Back end expands the head job into SPI bytes; the last byte of a job
  // pops it in the same cycle so the next job starts without a bubble.
  spifp_back #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_job_i     (head_job),
    .head_addr_i    (head_addr),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .spi_byte_o     (spi_byte_o),
    .end_select_o   (end_select_o),
    .capture_reply_o(capture_reply_o),
    .hold_reset_o   (hold_reset_o),
    .update_done_o  (update_done_o),
    .run_end_o      (run_end_o)
  );

endmodule
